FILE: design/mmp_pkg.sv
package mmp_pkg;

	localparam int CAL_SAMPLES_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEAD_BAND_X      = 3'd0,
		REG_DEAD_BAND_Y      = 3'd1,
		REG_DEAD_BAND_Z      = 3'd2,
		REG_HYSTERESIS       = 3'd3,
		REG_SCROLL_THRESHOLD = 3'd4,
		REG_STILL_TIMEOUT_MS = 3'd5
	} cfg_reg_e;

	localparam logic [14:0] DEADZONE_RST         = 15'd5;
	localparam logic [15:0] HYSTERESIS_RST       = 16'd2;
	localparam logic [15:0] SCROLL_THRESHOLD_RST = 16'd50;
	localparam logic [31:0] STILL_TIMEOUT_RST    = 32'd5000;

	localparam logic signed [1:0] SCROLL_NONE = 2'sb00;
	localparam logic signed [1:0] SCROLL_UP   = 2'sb01;
	localparam logic signed [1:0] SCROLL_DOWN = 2'sb11;

	typedef struct packed {
		logic [14:0] dead_band_x;
		logic [14:0] dead_band_y;
		logic [14:0] dead_band_z;
		logic [15:0] hysteresis;
		logic [15:0] scroll_threshold;
		logic [31:0] still_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} vec3_t;

	typedef struct packed {
		logic busy;
	} div_status_t;

endpackage

FILE: design/mmp_if.sv
interface mmp_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] raw_x;
	logic signed [15:0] raw_y;
	logic signed [15:0] raw_z;
	logic [31:0]        time_ms;

	modport source (output valid, raw_x, raw_y, raw_z, time_ms, input ready);
	modport sink (input valid, raw_x, raw_y, raw_z, time_ms, output ready);
endinterface

interface mmp_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] move_x;
	logic signed [15:0] move_y;
	logic signed [1:0]  scroll;
	logic               report;
	logic               collecting;
	logic               calibrated;

	modport source (output valid, move_x, move_y, scroll, report, collecting, calibrated,
		input ready);
	modport sink (input valid, move_x, move_y, scroll, report, collecting, calibrated,
		output ready);
endinterface

FILE: design/mmp_cfg_regs.sv
module mmp_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mmp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mmp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output mmp_pkg::cfg_t                    cfg
);

	mmp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_band_x      <= mmp_pkg::DEADZONE_RST;
			cfg_q.dead_band_y      <= mmp_pkg::DEADZONE_RST;
			cfg_q.dead_band_z      <= mmp_pkg::DEADZONE_RST;
			cfg_q.hysteresis       <= mmp_pkg::HYSTERESIS_RST;
			cfg_q.scroll_threshold <= mmp_pkg::SCROLL_THRESHOLD_RST;
			cfg_q.still_timeout_ms <= mmp_pkg::STILL_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (mmp_pkg::cfg_reg_e'(cfg_index))
				mmp_pkg::REG_DEAD_BAND_X:      cfg_q.dead_band_x      <= cfg_data[14:0];
				mmp_pkg::REG_DEAD_BAND_Y:      cfg_q.dead_band_y      <= cfg_data[14:0];
				mmp_pkg::REG_DEAD_BAND_Z:      cfg_q.dead_band_z      <= cfg_data[14:0];
				mmp_pkg::REG_HYSTERESIS:       cfg_q.hysteresis       <= cfg_data[15:0];
				mmp_pkg::REG_SCROLL_THRESHOLD: cfg_q.scroll_threshold <= cfg_data[15:0];
				mmp_pkg::REG_STILL_TIMEOUT_MS: cfg_q.still_timeout_ms <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/mmp_cal_div.sv
module mmp_cal_div #(
	parameter int CAL_SAMPLES = mmp_pkg::CAL_SAMPLES_DEF,
	parameter int SUM_W       = 16 + $clog2(CAL_SAMPLES + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [SUM_W-1:0]  sum_x,
	input  logic signed [SUM_W-1:0]  sum_y,
	input  logic signed [SUM_W-1:0]  sum_z,
	output mmp_pkg::vec3_t           offset,
	output mmp_pkg::div_status_t     status
);

	// The quotient is the product with a rounded-up reciprocal, which is exact
	// for every magnitude below two to the power of the magnitude width.
	localparam int M_W   = SUM_W;
	localparam int SHIFT = M_W + $clog2(CAL_SAMPLES);
	localparam int R_W   = M_W + 1;
	localparam int P_W   = M_W + R_W;
	localparam logic [R_W-1:0] RECIP =
		R_W'(((longint'(1) << SHIFT) + longint'(CAL_SAMPLES) - 1) / longint'(CAL_SAMPLES));

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAG,
		ST_MUL,
		ST_WR
	} state_t;

	typedef enum logic [1:0] {
		AX_X,
		AX_Y,
		AX_Z
	} axis_t;

	state_t             state_q;
	axis_t              axis_q;
	mmp_pkg::vec3_t     offset_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic signed [SUM_W-1:0] sel_sum;
	logic [M_W-1:0]     sel_mag;
	logic [M_W-1:0]     mag_q;
	logic               neg_q;
	logic [P_W-1:0]     prod_q;
	logic [15:0]        quot;
	logic signed [15:0] quot_signed;

	always_comb begin
		unique case (axis_q)
			AX_X:    sel_sum = sum_x_q;
			AX_Y:    sel_sum = sum_y_q;
			AX_Z:    sel_sum = sum_z_q;
			default: sel_sum = sum_z_q;
		endcase
	end

	assign sel_mag     = sel_sum[SUM_W-1] ? M_W'(-sel_sum) : M_W'(sel_sum);
	assign quot        = 16'(prod_q >> SHIFT);
	assign quot_signed = neg_q ? -$signed(quot) : $signed(quot);

	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			sum_x_q <= sum_x;
			sum_y_q <= sum_y;
			sum_z_q <= sum_z;
		end
		if (state_q == ST_MAG) begin
			mag_q <= sel_mag;
			neg_q <= sel_sum[SUM_W-1];
		end
		if (state_q == ST_MUL) begin
			prod_q <= P_W'(mag_q) * P_W'(RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			axis_q   <= AX_X;
			offset_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						axis_q  <= AX_X;
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					unique case (axis_q)
						AX_X: begin
							offset_q.x <= quot_signed;
							axis_q     <= AX_Y;
							state_q    <= ST_MAG;
						end
						AX_Y: begin
							offset_q.y <= quot_signed;
							axis_q     <= AX_Z;
							state_q    <= ST_MAG;
						end
						default: begin
							offset_q.z <= quot_signed;
							axis_q     <= AX_X;
							state_q    <= ST_IDLE;
						end
					endcase
				end
			endcase
		end
	end

	assign offset      = offset_q;
	assign status.busy = (state_q != ST_IDLE);

endmodule

FILE: design/mmp_core.sv
module mmp_core #(
	parameter int CAL_SAMPLES = mmp_pkg::CAL_SAMPLES_DEF,
	parameter int SUM_W       = 16 + $clog2(CAL_SAMPLES + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	mmp_sample_if.sink               sample,
	mmp_result_if.source             result,
	input  mmp_pkg::cfg_t            cfg,
	input  mmp_pkg::vec3_t           offset,
	input  mmp_pkg::div_status_t     div_status,
	output logic                     cal_start,
	output logic signed [SUM_W-1:0]  cal_sum_x,
	output logic signed [SUM_W-1:0]  cal_sum_y,
	output logic signed [SUM_W-1:0]  cal_sum_z
);

	localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAL_SAMPLES);

	function automatic logic [16:0] mag17(input logic signed [15:0] v);
		logic signed [16:0] w;
		w = {v[15], v};
		return v[15] ? 17'(-w) : 17'(w);
	endfunction

	logic               valid_s1;
	logic signed [15:0] raw_x_s1, raw_y_s1, raw_z_s1;
	logic [31:0]        time_s1;

	logic               primed_q;
	logic               cal_pending_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic signed [15:0] prev_x_q, prev_y_q, prev_z_q;
	logic [31:0]        last_q;

	logic               out_valid_q;
	logic signed [15:0] move_x_q, move_y_q;
	logic signed [1:0]  scroll_q;
	logic               report_q, collecting_q, calibrated_q;

	logic signed [15:0] cx, cy, cz, dx, dy, dz, mvx, mvy;
	logic [16:0]        mag_x, mag_y, mag_z;
	logic               motion, still, calib_item, add, cal_done, fire, report;
	logic signed [1:0]  scroll;
	logic [31:0]        still_ms;
	logic [CNT_W-1:0]   cnt_base, cnt_nx;
	logic signed [SUM_W-1:0] sx_base, sy_base, sz_base, sx_nx, sy_nx, sz_nx;

	assign cx = raw_x_s1 - offset.x;
	assign cy = raw_y_s1 - offset.y;
	assign cz = raw_z_s1 - offset.z;
	assign dx = cx - prev_x_q;
	assign dy = cy - prev_y_q;
	assign dz = cz - prev_z_q;
	assign mag_x = mag17(dx);
	assign mag_y = mag17(dy);
	assign mag_z = mag17(dz);

	assign motion = (mag_x > {2'b00, cfg.dead_band_x}) || (mag_y > {2'b00, cfg.dead_band_y}) ||
		(mag_z > {2'b00, cfg.dead_band_z});
	assign still_ms   = time_s1 - last_q;
	assign still      = still_ms > cfg.still_timeout_ms;
	assign calib_item = primed_q && !motion && still;

	assign mvx = (mag_x < {1'b0, cfg.hysteresis}) ? 16'sd0 : dx;
	assign mvy = (mag_y < {1'b0, cfg.hysteresis}) ? 16'sd0 : dy;

	always_comb begin
		scroll = mmp_pkg::SCROLL_NONE;
		if (!(mag_z < {1'b0, cfg.hysteresis}) && (mag_z > {1'b0, cfg.scroll_threshold})) begin
			scroll = dz[15] ? mmp_pkg::SCROLL_DOWN : mmp_pkg::SCROLL_UP;
		end
	end

	assign report = (mvx != 16'sd0) || (mvy != 16'sd0) || (scroll != mmp_pkg::SCROLL_NONE);

	// A new sampling run starts from an empty count and zero sums.
	assign cnt_base = cal_pending_q ? cnt_q : '0;
	assign sx_base  = cal_pending_q ? sum_x_q : '0;
	assign sy_base  = cal_pending_q ? sum_y_q : '0;
	assign sz_base  = cal_pending_q ? sum_z_q : '0;
	assign add      = cnt_base < CNT_FULL;
	assign cnt_nx   = add ? cnt_base + CNT_W'(1) : cnt_base;
	assign sx_nx    = add ? sx_base + SUM_W'(raw_x_s1) : sx_base;
	assign sy_nx    = add ? sy_base + SUM_W'(raw_y_s1) : sy_base;
	assign sz_nx    = add ? sz_base + SUM_W'(raw_z_s1) : sz_base;
	assign cal_done = cnt_nx >= CNT_FULL;

	assign fire      = valid_s1 && (!out_valid_q || result.ready);
	assign cal_start = fire && calib_item && cal_done;
	assign cal_sum_x = sx_nx;
	assign cal_sum_y = sy_nx;
	assign cal_sum_z = sz_nx;

	// The offsets are rewritten after a calibrating transaction, so no new
	// sample enters until the divider has finished.
	assign sample.ready = (!valid_s1 || fire) && !div_status.busy &&
		!(valid_s1 && calib_item && cal_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.valid && sample.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			raw_x_s1 <= sample.raw_x;
			raw_y_s1 <= sample.raw_y;
			raw_z_s1 <= sample.raw_z;
			time_s1  <= sample.time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q      <= 1'b0;
			cal_pending_q <= 1'b0;
			cnt_q         <= '0;
			sum_x_q       <= '0;
			sum_y_q       <= '0;
			sum_z_q       <= '0;
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			prev_z_q      <= '0;
			last_q        <= '0;
		end else if (fire) begin
			priority if (!primed_q) begin
				primed_q <= 1'b1;
				prev_x_q <= cx;
				prev_y_q <= cy;
				prev_z_q <= cz;
				last_q   <= time_s1;
			end else if (calib_item) begin
				cal_pending_q <= !cal_done;
				cnt_q         <= cal_done ? '0 : cnt_nx;
				sum_x_q       <= sx_nx;
				sum_y_q       <= sy_nx;
				sum_z_q       <= sz_nx;
			end else begin
				if (motion) begin
					last_q <= time_s1;
				end
				prev_x_q <= cx;
				prev_y_q <= cy;
				prev_z_q <= cz;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (primed_q && !calib_item) begin
				move_x_q <= mvx;
				move_y_q <= mvy;
				scroll_q <= scroll;
				report_q <= report;
			end else begin
				move_x_q <= '0;
				move_y_q <= '0;
				scroll_q <= mmp_pkg::SCROLL_NONE;
				report_q <= 1'b0;
			end
			collecting_q <= calib_item;
			calibrated_q <= calib_item && cal_done;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.move_x     = move_x_q;
	assign result.move_y     = move_y_q;
	assign result.scroll     = scroll_q;
	assign result.report     = report_q;
	assign result.collecting = collecting_q;
	assign result.calibrated = calibrated_q;

endmodule

FILE: design/magnetometer_motion_to_pointer.sv
// A sample passes through the input register and then the result register on its
// way to the result transaction. Throughput: one sample per cycle while the result
// side is ready; after a sample that completes calibration, input stalls while one
// shared multiplier computes the three offsets, each axis through the magnitude,
// multiply and write states. Reset: asynchronous, active low; control and offset
// state clears to zero and config registers take defaults; data is not reset.
module magnetometer_motion_to_pointer #(
	parameter int CAL_SAMPLES = mmp_pkg::CAL_SAMPLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	mmp_sample_if.sink                      sample,
	mmp_result_if.source                    result,
	input  logic                            cfg_we,
	input  logic [mmp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mmp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int SUM_W = 16 + $clog2(CAL_SAMPLES + 1);

	mmp_pkg::cfg_t           cfg;
	mmp_pkg::vec3_t          offset;
	mmp_pkg::div_status_t    div_status;
	logic                    cal_start;
	logic signed [SUM_W-1:0] cal_sum_x, cal_sum_y, cal_sum_z;

	mmp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mmp_core #(
		.CAL_SAMPLES (CAL_SAMPLES),
		.SUM_W       (SUM_W)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.result     (result),
		.cfg        (cfg),
		.offset     (offset),
		.div_status (div_status),
		.cal_start  (cal_start),
		.cal_sum_x  (cal_sum_x),
		.cal_sum_y  (cal_sum_y),
		.cal_sum_z  (cal_sum_z)
	);

	mmp_cal_div #(
		.CAL_SAMPLES (CAL_SAMPLES),
		.SUM_W       (SUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cal_start),
		.sum_x  (cal_sum_x),
		.sum_y  (cal_sum_y),
		.sum_z  (cal_sum_z),
		.offset (offset),
		.status (div_status)
	);

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |-> !div_status.busy)
		else $error("Sample transaction accepted while offsets are being computed.");

	a_start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cal_start |=> div_status.busy)
		else $error("Calibration start did not launch the divider.");

	a_calibrated_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.calibrated) |-> (result.collecting && !result.report))
		else $error("Calibrating result carries inconsistent flags.");

	a_report_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.report) |->
		(result.move_x != 16'sd0 || result.move_y != 16'sd0 ||
		result.scroll != mmp_pkg::SCROLL_NONE))
		else $error("Report flag set without any movement or scroll.");

endmodule

FILE: tb/sv/magnetometer_motion_to_pointer_tb.sv
`timescale 1ns / 1ps

typedef struct packed {
	logic signed [15:0] move_x;
	logic signed [15:0] move_y;
	logic signed [1:0]  scroll;
	logic               report;
	logic               collecting;
	logic               calibrated;
} pointer_move_t;

class pointer_tracker;
	localparam int MAX_REPORTS = 200;

	mmp_pkg::cfg_t      cfg;
	logic signed [15:0] offset_x, offset_y, offset_z;
	logic signed [15:0] prev_x, prev_y, prev_z;
	logic [31:0]        last_motion_ms;
	bit                 primed;
	bit                 cal_pending;
	int                 cal_count;
	int                 sum_x, sum_y, sum_z;
	int                 errors;
	pointer_move_t      expected_moves[$];

	function new();
		cfg.dead_band_x = mmp_pkg::DEADZONE_RST;
		cfg.dead_band_y = mmp_pkg::DEADZONE_RST;
		cfg.dead_band_z = mmp_pkg::DEADZONE_RST;
		cfg.hysteresis = mmp_pkg::HYSTERESIS_RST;
		cfg.scroll_threshold = mmp_pkg::SCROLL_THRESHOLD_RST;
		cfg.still_timeout_ms = mmp_pkg::STILL_TIMEOUT_RST;
		offset_x = '0;
		offset_y = '0;
		offset_z = '0;
		prev_x = '0;
		prev_y = '0;
		prev_z = '0;
		last_motion_ms = '0;
	endfunction

	function void write_reg(logic [mmp_pkg::CFG_IDX_W-1:0] idx,
			logic [mmp_pkg::CFG_DATA_W-1:0] data);
		unique case (idx)
			mmp_pkg::REG_DEAD_BAND_X: cfg.dead_band_x = data[14:0];
			mmp_pkg::REG_DEAD_BAND_Y: cfg.dead_band_y = data[14:0];
			mmp_pkg::REG_DEAD_BAND_Z: cfg.dead_band_z = data[14:0];
			mmp_pkg::REG_HYSTERESIS: cfg.hysteresis = data[15:0];
			mmp_pkg::REG_SCROLL_THRESHOLD: cfg.scroll_threshold = data[15:0];
			mmp_pkg::REG_STILL_TIMEOUT_MS: cfg.still_timeout_ms = data;
			default: ;
		endcase
	endfunction

	function bit beyond(logic signed [15:0] d, logic [14:0] lim);
		return int'(d) > int'(lim) || int'(d) < -int'(lim);
	endfunction

	function int magnitude(logic signed [15:0] d);
		return (d < 0) ? -int'(d) : int'(d);
	endfunction

	function void take_sample(logic signed [15:0] rx, logic signed [15:0] ry,
			logic signed [15:0] rz, logic [31:0] now);
		logic signed [15:0] cx, cy, cz, dx, dy, dz;
		logic               motion;
		pointer_move_t      want;
		want = '0;
		cx = rx - offset_x;
		cy = ry - offset_y;
		cz = rz - offset_z;
		if (!primed) begin
			primed = 1'b1;
			prev_x = cx;
			prev_y = cy;
			prev_z = cz;
			last_motion_ms = now;
			expected_moves.push_back(want);
			return;
		end
		dx = cx - prev_x;
		dy = cy - prev_y;
		dz = cz - prev_z;
		motion = beyond(dx, cfg.dead_band_x) || beyond(dy, cfg.dead_band_y) ||
			beyond(dz, cfg.dead_band_z);
		if (motion)
			last_motion_ms = now;
		if (!motion && (now - last_motion_ms) > cfg.still_timeout_ms) begin
			if (!cal_pending) begin
				cal_pending = 1'b1;
				cal_count = 0;
				sum_x = 0;
				sum_y = 0;
				sum_z = 0;
			end
			if (cal_count < mmp_pkg::CAL_SAMPLES_DEF) begin
				sum_x += rx;
				sum_y += ry;
				sum_z += rz;
				cal_count++;
			end
			want.collecting = 1'b1;
			if (cal_count >= mmp_pkg::CAL_SAMPLES_DEF) begin
				offset_x = 16'(sum_x / cal_count);
				offset_y = 16'(sum_y / cal_count);
				offset_z = 16'(sum_z / cal_count);
				cal_pending = 1'b0;
				cal_count = 0;
				want.calibrated = 1'b1;
			end
			expected_moves.push_back(want);
			return;
		end
		if (magnitude(dx) < int'(cfg.hysteresis)) dx = '0;
		if (magnitude(dy) < int'(cfg.hysteresis)) dy = '0;
		if (magnitude(dz) < int'(cfg.hysteresis)) dz = '0;
		if (magnitude(dz) > int'(cfg.scroll_threshold))
			want.scroll = (dz > 0) ? mmp_pkg::SCROLL_UP : mmp_pkg::SCROLL_DOWN;
		want.move_x = dx;
		want.move_y = dy;
		want.report = (dx != 0) || (dy != 0) || (want.scroll != mmp_pkg::SCROLL_NONE);
		prev_x = cx;
		prev_y = cy;
		prev_z = cz;
		expected_moves.push_back(want);
	endfunction

	function void check_move(pointer_move_t got);
		pointer_move_t want;
		if (expected_moves.size() == 0) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: unexpected result x=%0d y=%0d scroll=%0d report=%b collecting=%b calibrated=%b",
					$time, got.move_x, got.move_y, got.scroll, got.report,
					got.collecting, got.calibrated);
			return;
		end
		want = expected_moves.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display({"%0t: result mismatch: expected x=%0d y=%0d scroll=%0d report=%b ",
					"collecting=%b calibrated=%b, got x=%0d y=%0d scroll=%0d report=%b ",
					"collecting=%b calibrated=%b"},
					$time, want.move_x, want.move_y, want.scroll, want.report,
					want.collecting, want.calibrated, got.move_x, got.move_y,
					got.scroll, got.report, got.collecting, got.calibrated);
		end
	endfunction
endclass

module magnetometer_motion_to_pointer_tb;
	localparam int IDLE_LIMIT    = 1000;
	localparam int SETTLE_CYCLES = 16;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [mmp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mmp_pkg::CFG_DATA_W-1:0] cfg_data;

	mmp_sample_if sample_bus();
	mmp_result_if result_bus();

	pointer_tracker tracker;
	bit             src_rush;
	bit             snk_rush;
	int             stall_left;
	logic [31:0]    clock_ms;

	magnetometer_motion_to_pointer dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_bus),
		.result(result_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_bus.ready <= 1'b0;
			stall_left--;
		end else begin
			result_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (result_bus.valid && result_bus.ready) begin
			tracker.check_move({result_bus.move_x, result_bus.move_y, result_bus.scroll,
				result_bus.report, result_bus.collecting, result_bus.calibrated});
			stall_left = snk_rush ? 0 : $urandom_range(0, 11);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((sample_bus.valid && sample_bus.ready) ||
					(result_bus.valid && result_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	task automatic send_sample(logic signed [15:0] rx, logic signed [15:0] ry,
			logic signed [15:0] rz, logic [31:0] t);
		int gap;
		gap = src_rush ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			@(negedge clk);
			sample_bus.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_bus.valid <= 1'b1;
		sample_bus.raw_x <= rx;
		sample_bus.raw_y <= ry;
		sample_bus.raw_z <= rz;
		sample_bus.time_ms <= t;
		@(posedge clk);
		while (!sample_bus.ready) @(posedge clk);
		tracker.take_sample(rx, ry, rz, t);
	endtask

	task automatic settle();
		@(negedge clk);
		sample_bus.valid <= 1'b0;
		while (tracker.expected_moves.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [mmp_pkg::CFG_IDX_W-1:0] idx,
			logic [mmp_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
	endtask

	function automatic logic [31:0] pad(logic [31:0] v, int w);
		return ($urandom() << w) | (v & ((32'h1 << w) - 32'h1));
	endfunction

	task automatic apply_config(logic [31:0] dzx, logic [31:0] dzy, logic [31:0] dzz,
			logic [31:0] hyst, logic [31:0] thr, logic [31:0] timeout);
		write_reg(3'(mmp_pkg::REG_STILL_TIMEOUT_MS) + 3'($urandom_range(1, 2)), $urandom());
		write_reg(mmp_pkg::REG_DEAD_BAND_X, pad(dzx, 15));
		write_reg(mmp_pkg::REG_DEAD_BAND_Y, pad(dzy, 15));
		write_reg(mmp_pkg::REG_DEAD_BAND_Z, pad(dzz, 15));
		write_reg(mmp_pkg::REG_HYSTERESIS, pad(hyst, 16));
		write_reg(mmp_pkg::REG_SCROLL_THRESHOLD, pad(thr, 16));
		write_reg(mmp_pkg::REG_STILL_TIMEOUT_MS, timeout);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int spread(int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	// Stays within every deadzone of the stored position, so it reads as stillness.
	task automatic still_sample(logic [31:0] step);
		clock_ms += step;
		send_sample(tracker.prev_x + tracker.offset_x +
			16'(spread(int'(tracker.cfg.dead_band_x))),
			tracker.prev_y + tracker.offset_y + 16'(spread(int'(tracker.cfg.dead_band_y))),
			tracker.prev_z + tracker.offset_z + 16'(spread(int'(tracker.cfg.dead_band_z))),
			clock_ms);
	endtask

	task automatic motion_sample();
		int lim;
		case ($urandom_range(0, 3))
			0: lim = int'(tracker.cfg.hysteresis) + 2;
			1: lim = int'(tracker.cfg.dead_band_x) + 3;
			2: lim = int'(tracker.cfg.scroll_threshold) + 5;
			default: lim = 32768;
		endcase
		clock_ms += $urandom_range(0, 40);
		send_sample(tracker.prev_x + tracker.offset_x + 16'(spread(lim)),
			tracker.prev_y + tracker.offset_y + 16'(spread(lim)),
			tracker.prev_z + tracker.offset_z + 16'(spread(lim)),
			clock_ms);
	endtask

	task automatic noise_sample();
		clock_ms = $urandom();
		send_sample(16'($urandom()), 16'($urandom()), 16'($urandom()), clock_ms);
	endtask

	task automatic random_phase(int count);
		int sent;
		int n;
		sent = 0;
		while (sent < count) begin
			src_rush = ($urandom_range(0, 4) == 0);
			snk_rush = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					n = $urandom_range(10, 20);
					still_sample(tracker.cfg.still_timeout_ms + 32'd1 +
						32'($urandom_range(0, 200)));
					repeat (n - 1) still_sample($urandom_range(0, 60));
				end
				4, 5, 6, 7: begin
					n = $urandom_range(3, 15);
					repeat (n) motion_sample();
				end
				default: begin
					n = $urandom_range(1, 4);
					repeat (n) noise_sample();
				end
			endcase
			sent += n;
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_bus.valid = 1'b0;
		sample_bus.raw_x = '0;
		sample_bus.raw_y = '0;
		sample_bus.raw_z = '0;
		sample_bus.time_ms = '0;
		result_bus.ready = 1'b0;
		src_rush = 1'b0;
		snk_rush = 1'b0;
		tracker = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
		send_sample(16'h8000, 16'h8000, 16'h8000, 32'd1);
		send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd2);
		send_sample(16'h7FFF, 16'h8000, 16'h0000, 32'd3);
		send_sample(16'sd100, -16'sd100, 16'sd50, 32'd100);
		for (int i = 0; i < mmp_pkg::CAL_SAMPLES_DEF; i++)
			send_sample(16'(100 + i % 3), -16'sd100, 16'sd50, 32'(6000 + 7 * i));
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'hFFFF_FFF0);
		send_sample(16'sd1, 16'sd0, 16'sd0, 32'h0000_1400);
		send_sample(16'sd500, 16'sd0, 16'sd0, 32'h0000_1401);
		send_sample(16'sd500, 16'sd0, -16'sd40, 32'h0000_1402);
		send_sample(16'sd500, 16'sd0, 16'sd200, 32'h0000_1403);

		clock_ms = $urandom();
		random_phase(130);
		settle();
		apply_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		random_phase(130);
		settle();
		apply_config(32'h7FFF, 32'h7FFF, 32'h7FFF, 32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF);
		random_phase(130);
		settle();
		apply_config(32'd0, 32'd1, 32'd2, 32'h8000, 32'h8000, 32'd0);
		random_phase(130);
		repeat (5) begin
			settle();
			apply_config($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40),
				$urandom_range(0, 20), $urandom_range(0, 300), $urandom_range(0, 3000));
			random_phase(130);
		end
		settle();
		apply_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
		random_phase(100);
		settle();

		if (tracker.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
